FILE: design/smvm_pkg.sv
// Shared types, codes and constants for the sparse matrix-vector multiply core.
`timescale 1ns / 1ps

package smvm_pkg;

   // Field widths of the request and response items.
   localparam int DATA_W  = 32;
   localparam int ACC_W   = 64;
   localparam int INDEX_W = 10;
   localparam int ROW_W   = 16;

   // Default sizes of the x store and of the row counter range.
   localparam int X_DEPTH_DEFAULT  = 1024;
   localparam int MAX_ROWS_DEFAULT = 65536;

   // Reset values of the gain registers (Q16.16).
   localparam logic signed [DATA_W-1:0] ALPHA_RESET = 32'sd65536;
   localparam logic signed [DATA_W-1:0] BETA_RESET  = 32'sd0;

   // Saturation limits.
   localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] Z_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Z_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

   // Configuration register indexes.
   localparam logic REG_ALPHA = 1'b0;
   localparam logic REG_BETA  = 1'b1;

   // Request commands.
   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_NONZERO = 2'd1,
      CMD_FINISH  = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   // Operands of one finished row, handed to the output pipeline.
   typedef struct packed {
      logic signed [ACC_W-1:0]  acc;
      logic signed [DATA_W-1:0] y;
      logic [ROW_W-1:0]         row;
   } fin_op_type;

endpackage

FILE: design/smvm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module smvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/smvm_accum.sv
// Multiply stage and saturating row accumulator with the row counter.
`timescale 1ns / 1ps

module smvm_accum import smvm_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  cmd_type                  in_cmd,
   input  logic signed [DATA_W-1:0] in_value,
   input  logic signed [DATA_W-1:0] in_y,
   input  logic [DATA_W-1:0]        x_data,
   output logic                     fin_valid,
   input  logic                     fin_ready,
   output fin_op_type               fin_op
);

   localparam int CNT_W = $clog2(MAX_ROWS);
   localparam logic [CNT_W-1:0] ROW_LAST = CNT_W'(MAX_ROWS - 1);

   // Stage 1: request waits for the x read data.
   logic                     v1_ff, v1_in;
   cmd_type                  cmd1_ff;
   logic signed [DATA_W-1:0] val1_ff;
   logic signed [DATA_W-1:0] y1_ff;

   // Stage 2: registered product.
   logic                     v2_ff, v2_in;
   cmd_type                  cmd2_ff;
   logic signed [ACC_W-1:0]  prod2_ff, prod2_in;
   logic signed [DATA_W-1:0] y2_ff;

   // Row state.
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]         row_ff, row_in;

   logic                     ready1, ready2, fire2;
   logic signed [ACC_W-1:0]  addend, sum;
   logic                     ovf;

   // Stage handshakes: only a finish request can hold stage 2.
   assign ready2   = !v2_ff || (cmd2_ff != CMD_FINISH) || fin_ready;
   assign ready1   = !v1_ff || ready2;
   assign fire2    = v2_ff && ready2;
   assign in_ready = ready1;

   assign v1_in    = ready1 ? in_valid : v1_ff;
   assign v2_in    = ready2 ? v1_ff : v2_ff;
   assign prod2_in = val1_ff * $signed(x_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         cmd1_ff <= in_cmd;
         val1_ff <= in_value;
         y1_ff   <= in_y;
      end
      if (ready2 && v1_ff) begin
         cmd2_ff  <= cmd1_ff;
         prod2_ff <= prod2_in;
         y2_ff    <= y1_ff;
      end
   end

   // Saturating add of the product floored to Q48.16.
   always_comb begin
      addend = prod2_ff >>> 16;
      sum    = acc_ff + addend;
      ovf    = (acc_ff[ACC_W-1] == addend[ACC_W-1]) && (sum[ACC_W-1] != acc_ff[ACC_W-1]);
   end

   // Row state update as each request leaves stage 2.
   always_comb begin
      acc_in = acc_ff;
      row_in = row_ff;
      if (fire2) begin
         case (cmd2_ff)
            CMD_NONZERO: begin
               if (ovf) begin
                  acc_in = acc_ff[ACC_W-1] ? ACC_MIN : ACC_MAX;
               end else begin
                  acc_in = sum;
               end
            end
            CMD_FINISH: begin
               acc_in = '0;
               row_in = (row_ff == ROW_LAST) ? '0 : row_ff + 1'b1;
            end
            CMD_RESTART: begin
               acc_in = '0;
               row_in = '0;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         row_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         row_ff <= row_in;
      end
   end

   // Finish request toward the output pipeline.
   assign fin_valid  = v2_ff && (cmd2_ff == CMD_FINISH);
   assign fin_op.acc = acc_ff;
   assign fin_op.y   = y2_ff;
   assign fin_op.row = ROW_W'(row_ff);

   // A restart leaves an empty row at row zero.
   assert property (@(posedge clock) disable iff (reset)
      fire2 && (cmd2_ff == CMD_RESTART) |=> (acc_ff == '0) && (row_ff == '0))
      else $error("restart did not clear the row state");

   // A finished row clears the sum and steps the counter.
   assert property (@(posedge clock) disable iff (reset)
      fire2 && (cmd2_ff == CMD_FINISH) |=> (acc_ff == '0) &&
         (row_ff == (($past(row_ff) == ROW_LAST) ? '0 : $past(row_ff) + 1'b1)))
      else $error("finish did not advance the row");

   // Requests are refused only behind a stalled finish.
   assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> v1_ff && v2_ff && (cmd2_ff == CMD_FINISH) && !fin_ready)
      else $error("request refused without a stalled finish");

endmodule

FILE: design/smvm_finish.sv
// Output pipeline: alpha*sum + beta*y, floored to Q16.16 and saturated.
`timescale 1ns / 1ps

module smvm_finish import smvm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [DATA_W-1:0] alpha_gain,
   input  logic signed [DATA_W-1:0] beta_gain,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  fin_op_type               in_op,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [ROW_W-1:0]         out_row,
   output logic signed [DATA_W-1:0] out_z
);

   // Stage B: the three partial products.
   logic                     vb_ff;
   logic signed [63:0]       p_b_ff;
   logic signed [64:0]       t1_b_ff;
   logic signed [63:0]       t2_b_ff;
   logic [ROW_W-1:0]         row_b_ff;

   // Stage C: low sum and high product.
   logic                     vc_ff;
   logic signed [63:0]       p_c_ff;
   logic signed [65:0]       s_c_ff, s_c_in;
   logic [ROW_W-1:0]         row_c_ff;

   // Stage D: result register.
   logic                     vd_ff;
   logic [ROW_W-1:0]         row_d_ff;
   logic signed [DATA_W-1:0] z_d_ff, z_d_in;

   logic                     ready_b, ready_c, ready_d;
   logic signed [DATA_W-1:0] acc_hi;
   logic [DATA_W-1:0]        acc_lo;
   logic signed [65:0]       h;

   assign ready_d  = !vd_ff || out_ready;
   assign ready_c  = !vc_ff || ready_d;
   assign ready_b  = !vb_ff || ready_c;
   assign in_ready = ready_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (ready_b) vb_ff <= in_valid;
         if (ready_c) vc_ff <= vb_ff;
         if (ready_d) vd_ff <= vc_ff;
      end
   end

   // Split the sum into a signed upper and an unsigned lower word.
   assign acc_hi = in_op.acc[ACC_W-1:DATA_W];
   assign acc_lo = in_op.acc[DATA_W-1:0];

   // Sum of the lower terms; the upper product carries weight 2^32.
   assign s_c_in = t1_b_ff + t2_b_ff;

   // Combine, floor by 2^16 and saturate to 32 bits.
   always_comb begin
      h = p_c_ff + $signed(s_c_ff[65:32]);
      if (h > 66'sd32767) begin
         z_d_in = Z_MAX;
      end else if (h < -66'sd32768) begin
         z_d_in = Z_MIN;
      end else begin
         z_d_in = {h[15:0], s_c_ff[31:16]};
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b && in_valid) begin
         p_b_ff   <= alpha_gain * acc_hi;
         t1_b_ff  <= alpha_gain * $signed({1'b0, acc_lo});
         t2_b_ff  <= beta_gain * in_op.y;
         row_b_ff <= in_op.row;
      end
      if (ready_c && vb_ff) begin
         p_c_ff   <= p_b_ff;
         s_c_ff   <= s_c_in;
         row_c_ff <= row_b_ff;
      end
      if (ready_d && vc_ff) begin
         z_d_ff   <= z_d_in;
         row_d_ff <= row_c_ff;
      end
   end

   assign out_valid = vd_ff;
   assign out_row   = row_d_ff;
   assign out_z     = z_d_ff;

   // A finish is held back only when every stage is full and stalled.
   assert property (@(posedge clock) disable iff (reset)
      in_valid && !in_ready |-> vb_ff && vc_ff && vd_ff && !out_ready)
      else $error("finish refused while the pipeline had room");

endmodule

FILE: design/sparse_matrix_vector_multiply_core.sv
// Top level of the streaming compressed-row sparse matrix-vector multiply core.
//
// Computes z = alpha*A*x + beta*y in Q16.16 over a stream of requests on the
// req_ channel. The command in req_tuser selects the work: load an x element,
// accumulate one nonzero against x at its column, finish a row, or restart at
// row zero. Only a finish produces a response on rsp_, carrying the row number
// and the saturated z value. The gains must be written on the csr_ channel
// while the core is idle; the core does not enforce this. csr_ready is always high.
// Throughput: one request per cycle unless a stalled finish holds req_tready low,
// set by the single x store read port and the one multiply-accumulate per cycle in
// the row accumulator. A finish passes through the x read, product, partial product,
// low sum and result registers before it appears on rsp_.
// When rsp_tready is low the output pipeline keeps filling; req_tready falls
// once its three stages and the accumulator stage each hold a finish and one
// more request waits behind them.
// Reset clears the row sum, the row counter and the pipeline, and sets
// alpha to 1.0 and beta to 0. The x store is not cleared: load each x element
// before a nonzero reads it.
`timescale 1ns / 1ps

module sparse_matrix_vector_multiply_core import smvm_pkg::*; #(
   parameter int X_DEPTH  = X_DEPTH_DEFAULT,
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // index[9:0], value[41:10], y_value[73:42], zero pad
   input  logic [1:0]  req_tuser,   // command[1:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // row_number[15:0], z_value[47:16]
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int AW    = $clog2(X_DEPTH);
   localparam int RED_W = INDEX_W + 18;

   logic signed [DATA_W-1:0] alpha_ff, alpha_in;
   logic signed [DATA_W-1:0] beta_ff, beta_in;

   logic                     req_fire;
   cmd_type                  req_cmd;
   logic [INDEX_W-1:0]       req_index;
   logic signed [DATA_W-1:0] req_value;
   logic signed [DATA_W-1:0] req_y;
   logic [RED_W-1:0]         rem;
   logic [AW-1:0]            x_addr;
   logic [DATA_W-1:0]        x_data;

   logic                     fin_valid, fin_ready;
   fin_op_type               fin_op;
   logic [ROW_W-1:0]         rsp_row;
   logic signed [DATA_W-1:0] rsp_z;

   // Unpack the request.
   assign req_cmd   = cmd_type'(req_tuser);
   assign req_index = req_tdata[9:0];
   assign req_value = req_tdata[41:10];
   assign req_y     = req_tdata[73:42];
   assign req_fire  = req_tvalid && req_tready;

   // Column index reduced modulo the store depth by restoring subtraction.
   always_comb begin
      rem = RED_W'(req_index);
      for (int k = INDEX_W - 1; k >= 0; k--) begin
         if (rem >= (RED_W'(X_DEPTH) << k)) begin
            rem = rem - (RED_W'(X_DEPTH) << k);
         end
      end
   end
   assign x_addr = AW'(rem);

   // Gain registers.
   assign csr_ready = 1'b1;

   always_comb begin
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ALPHA: alpha_in = csr_data;
            REG_BETA:  beta_in  = csr_data;
            default:   alpha_in = alpha_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         beta_ff  <= BETA_RESET;
      end else begin
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
      end
   end

   // x store: loads write at acceptance, nonzeros read at acceptance.
   smvm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (X_DEPTH)
   ) u_x_store (
      .clock   (clock),
      .wr_en   (req_fire && (req_cmd == CMD_LOAD)),
      .wr_addr (x_addr),
      .wr_data (req_value),
      .rd_en   (req_fire && (req_cmd == CMD_NONZERO)),
      .rd_addr (x_addr),
      .rd_data (x_data)
   );

   // Product and row accumulation.
   smvm_accum #(
      .MAX_ROWS (MAX_ROWS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_cmd),
      .in_value  (req_value),
      .in_y      (req_y),
      .x_data    (x_data),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin_op    (fin_op)
   );

   // Scaling, rounding and saturation of finished rows.
   smvm_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .alpha_gain (alpha_ff),
      .beta_gain  (beta_ff),
      .in_valid   (fin_valid),
      .in_ready   (fin_ready),
      .in_op      (fin_op),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_row    (rsp_row),
      .out_z      (rsp_z)
   );

   assign rsp_tdata = {rsp_z, rsp_row};

endmodule

FILE: bench/smvm_checker.sv
// Checker that predicts and compares the responses of the sparse matrix-vector multiply core.
`timescale 1ns / 1ps

module smvm_checker import smvm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,   // index[9:0], value[41:10], y_value[73:42], zero pad
   input  logic [1:0]  req_tuser,   // command[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // row_number[15:0], z_value[47:16]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output int          error_count,
   output int          rows_awaited
);

   // One finished row as it should appear on the response channel.
   typedef struct packed {
      logic [ROW_W-1:0]         row;
      logic signed [DATA_W-1:0] z;
   } row_result_type;

   // Shadow copy of the core's state and gains.
   logic signed [DATA_W-1:0] x_copy [X_DEPTH_DEFAULT];
   logic signed [ACC_W-1:0]  sum_model = '0;
   logic [ROW_W-1:0]         row_model = '0;
   logic signed [DATA_W-1:0] alpha_model = ALPHA_RESET;
   logic signed [DATA_W-1:0] beta_model = BETA_RESET;
   row_result_type           awaited_rows[$];
   int                       fails = 0;

   // Exact Q16.16 product, floored back to Q48.16.
   function automatic logic signed [ACC_W-1:0] scaled_product(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b
   );
      logic signed [ACC_W-1:0] wide_a;
      logic signed [ACC_W-1:0] wide_b;
      logic signed [ACC_W-1:0] exact;
      wide_a = a;
      wide_b = b;
      exact = wide_a * wide_b;
      return exact >>> 16;
   endfunction

   // Row accumulation that clamps at the 64-bit signed limits.
   function automatic logic signed [ACC_W-1:0] saturating_sum(
      input logic signed [ACC_W-1:0] acc,
      input logic signed [ACC_W-1:0] term
   );
      logic [ACC_W:0] total;
      total = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
      if (total[ACC_W] != total[ACC_W-1]) begin
         return total[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return total[ACC_W-1:0];
   endfunction

   // z = floor((alpha*acc + beta*y) / 2^16), clamped to the 32-bit range.
   function automatic logic signed [DATA_W-1:0] z_for_row(
      input logic signed [DATA_W-1:0] alpha,
      input logic signed [DATA_W-1:0] beta,
      input logic signed [ACC_W-1:0]  acc,
      input logic signed [DATA_W-1:0] y
   );
      logic signed [127:0] wide_alpha;
      logic signed [127:0] wide_beta;
      logic signed [127:0] wide_acc;
      logic signed [127:0] wide_y;
      logic signed [127:0] total;
      logic signed [127:0] upper;
      logic signed [127:0] lower;
      wide_alpha = alpha;
      wide_beta = beta;
      wide_acc = acc;
      wide_y = y;
      upper = Z_MAX;
      lower = Z_MIN;
      total = (wide_alpha * wide_acc + wide_beta * wide_y) >>> 16;
      if (total > upper) begin
         return Z_MAX;
      end
      if (total < lower) begin
         return Z_MIN;
      end
      return total[DATA_W-1:0];
   endfunction

   // Follow every handshake on the three channels, oldest response first.
   always @(posedge clock) begin : watch
      cmd_type                  cmd;
      logic [INDEX_W-1:0]       idx;
      logic signed [DATA_W-1:0] val;
      logic signed [DATA_W-1:0] yv;
      logic [ROW_W-1:0]         got_row;
      logic signed [DATA_W-1:0] got_z;
      row_result_type           want;

      if (reset) begin
         sum_model = '0;
         row_model = '0;
         alpha_model = ALPHA_RESET;
         beta_model = BETA_RESET;
         awaited_rows.delete();
      end else begin
         // Compare a delivered response with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got_row = rsp_tdata[ROW_W-1:0];
            got_z = rsp_tdata[ROW_W +: DATA_W];
            if (awaited_rows.size() == 0) begin
               $error("unexpected response: row_number %0d z_value %0d", got_row, got_z);
               fails++;
            end else begin
               want = awaited_rows.pop_front();
               if (got_row != want.row) begin
                  $error("row_number: expected %0d, got %0d", want.row, got_row);
                  fails++;
               end
               if (got_z != want.z) begin
                  $error("z_value: expected %0d, got %0d", want.z, got_z);
                  fails++;
               end
            end
         end

         // Apply an accepted request to the shadow state.
         if (req_tvalid && req_tready) begin
            cmd = cmd_type'(req_tuser);
            idx = req_tdata[INDEX_W-1:0];
            val = req_tdata[INDEX_W +: DATA_W];
            yv = req_tdata[INDEX_W+DATA_W +: DATA_W];
            case (cmd)
               CMD_LOAD: begin
                  x_copy[idx] = val;
               end
               CMD_NONZERO: begin
                  sum_model = saturating_sum(sum_model, scaled_product(val, x_copy[idx]));
               end
               CMD_FINISH: begin
                  want.row = row_model;
                  want.z = z_for_row(alpha_model, beta_model, sum_model, yv);
                  awaited_rows.push_back(want);
                  row_model = row_model + 1'b1;
                  sum_model = '0;
               end
               default: begin
                  sum_model = '0;
                  row_model = '0;
               end
            endcase
         end

         // Gain writes.
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ALPHA) begin
               alpha_model = csr_data;
            end else begin
               beta_model = csr_data;
            end
         end
      end

      rows_awaited <= awaited_rows.size();
      error_count <= fails;
   end

endmodule

FILE: bench/sparse_matrix_vector_multiply_core_tb.sv
// Testbench top for the sparse matrix-vector multiply core: stimulus, idling and verdict.
`timescale 1ns / 1ps

module sparse_matrix_vector_multiply_core_tb import smvm_pkg::*; ();

   // Length of the rows built from the largest products.
   localparam int BIG_RUN = 24;
   // Random requests per segment.
   localparam int SEGMENT_ITEMS = 170;
   localparam int SEGMENTS = 6;
   // Cycles to let the pipeline settle after the last response.
   localparam int SETTLE_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;
   int          error_count;
   int          rows_awaited;

   int                 sender_idle_pct = 0;
   int                 receiver_stall_pct = 0;
   bit                 is_loaded [X_DEPTH_DEFAULT];
   logic [INDEX_W-1:0] loaded_cols[$];

   always #6 clock = ~clock;

   sparse_matrix_vector_multiply_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   smvm_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .rows_awaited (rows_awaited)
   );

   // The receiver stalls at random with the current percentage.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Hard stop in case the core hangs.
   initial begin
      #20000000;
      $display("sparse_matrix_vector_multiply_core_tb: errors");
      $finish;
   end

   // Q16.16 operand: modest values and full-range words alike, and some extremes.
   function automatic logic [DATA_W-1:0] rand_q();
      int pick;
      pick = $urandom_range(9);
      if (pick < 4) begin
         return $urandom();
      end
      if (pick < 8) begin
         return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
      end
      return (pick == 8) ? 32'h7FFF_FFFF : 32'h8000_0000;
   endfunction

   // A column whose x element has been written.
   function automatic logic [INDEX_W-1:0] pick_col();
      return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
   endfunction

   // Present one request, with random sender gaps, and wait until it is taken.
   task automatic send_request(
      input cmd_type            cmd,
      input logic [INDEX_W-1:0] idx,
      input logic [DATA_W-1:0]  val,
      input logic [DATA_W-1:0]  yv
   );
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      if (cmd == CMD_LOAD && !is_loaded[idx]) begin
         is_loaded[idx] = 1'b1;
         loaded_cols.push_back(idx);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, yv, val, idx};
      req_tuser <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted row has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rows_awaited != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both gains, keeping the channel valid between the two writes.
   task automatic write_gains(input logic [DATA_W-1:0] alpha, input logic [DATA_W-1:0] beta);
      csr_valid <= 1'b1;
      csr_index <= REG_ALPHA;
      csr_data <= alpha;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= REG_BETA;
      csr_data <= beta;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly whole rows with random content, plus loads, restarts and stray requests.
   task automatic random_traffic(input int count);
      int      sent;
      int      r;
      int      n;
      cmd_type cmd;
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(99);
         if (r < 8) begin
            cmd = cmd_type'($urandom_range(3));
            send_request(cmd, (cmd == CMD_NONZERO) ? pick_col() : INDEX_W'($urandom()),
                         $urandom(), $urandom());
            sent++;
         end else if (r < 16) begin
            n = $urandom_range(1, 6);
            repeat (n) send_request(CMD_LOAD, INDEX_W'($urandom()), rand_q(), $urandom());
            sent += n;
         end else if (r < 20) begin
            send_request(CMD_RESTART, INDEX_W'($urandom()), $urandom(), $urandom());
            sent++;
         end else begin
            // A row; now and then it runs into the next one without a finish.
            n = $urandom_range(0, 8);
            repeat (n) send_request(CMD_NONZERO, pick_col(), rand_q(), $urandom());
            sent += n;
            if ($urandom_range(9) != 0) begin
               send_request(CMD_FINISH, INDEX_W'($urandom()), $urandom(), rand_q());
               sent++;
            end
         end
      end
   endtask

   // Directed requests: field extremes, rounding, empty rows and restart.
   task automatic directed_requests();
      send_request(CMD_LOAD, 10'd0, 32'h7FFF_FFFF, 32'h0);
      send_request(CMD_LOAD, 10'd1023, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(CMD_LOAD, 10'd1, 32'h0001_0000, 32'h0);
      send_request(CMD_LOAD, 10'd2, 32'hFFFF_0000, 32'h0);
      send_request(CMD_LOAD, 10'd3, 32'h0000_0001, 32'h0);
      send_request(CMD_NONZERO, 10'd0, 32'h7FFF_FFFF, 32'h0);
      send_request(CMD_NONZERO, 10'd1023, 32'h8000_0000, 32'h0);
      send_request(CMD_FINISH, 10'd0, 32'h0, 32'h7FFF_FFFF);
      send_request(CMD_NONZERO, 10'd1, 32'h0001_8000, 32'h0);
      send_request(CMD_NONZERO, 10'd2, 32'h0000_8000, 32'h0);
      // Smallest negative product must floor to minus one LSB.
      send_request(CMD_NONZERO, 10'd3, 32'hFFFF_FFFF, 32'h0);
      send_request(CMD_FINISH, 10'd1023, 32'hFFFF_FFFF, 32'h8000_0000);
      // Empty row.
      send_request(CMD_FINISH, 10'd0, 32'h0, 32'h0);
      send_request(CMD_RESTART, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_NONZERO, 10'd1, 32'h0002_0000, 32'h0);
      send_request(CMD_FINISH, 10'd0, 32'h0, rand_q());
      send_request(CMD_LOAD, 10'h2AA, rand_q(), 32'h0);
      send_request(CMD_LOAD, 10'h155, rand_q(), 32'h0);
      send_request(CMD_NONZERO, 10'h2AA, rand_q(), 32'h0);
      send_request(CMD_NONZERO, 10'h155, rand_q(), 32'h0);
      send_request(CMD_FINISH, 10'h3FF, 32'hFFFF_FFFF, rand_q());
   endtask

   // Stimulus by segment: each one has its own gains, and an idling pattern picked by the segment number modulo four.
   initial begin : stimulus
      int seg;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg != 0) begin
            drain();
            case (seg)
               1: write_gains(32'h7FFF_FFFF, 32'h8000_0000);
               2: write_gains(32'h8000_0000, 32'h7FFF_FFFF);
               3: write_gains(32'h0, 32'h0);
               4: write_gains(32'h0001_0000, 32'h0001_0000);
               default: write_gains(32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000,
                                    32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000);
            endcase
         end
         case (seg % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 81;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 81;
            end
            default: begin
               sender_idle_pct = 12;
               receiver_stall_pct = 12;
            end
         endcase

         if (seg == 0) begin
            directed_requests();
            // A long row of the largest positive products, then a step back down.
            repeat (BIG_RUN) send_request(CMD_NONZERO, 10'd1023, 32'h8000_0000, 32'h0);
            send_request(CMD_NONZERO, 10'd0, 32'h8000_0000, 32'h0);
            send_request(CMD_FINISH, 10'd0, 32'h0, 32'h0);
            // A long row of the largest negative products.
            repeat (BIG_RUN) send_request(CMD_NONZERO, 10'd0, 32'h8000_0000, 32'h0);
            send_request(CMD_FINISH, 10'd0, 32'h0, 32'h0);
         end
         random_traffic(SEGMENT_ITEMS);
      end

      drain();
      if (error_count == 0) begin
         $display("sparse_matrix_vector_multiply_core_tb: clean");
      end else begin
         $display("sparse_matrix_vector_multiply_core_tb: errors");
      end
      $finish;
   end

endmodule
